### rtl/lomh_pkg.sv
// Shared constants and types for the limit order matcher.
package lomh_pkg;

    localparam int BOOK_DEPTH_DEF  = 1024;
    localparam int PRICE_WIDTH_DEF = 32;

    // Commands from the controller to the datapath.
    localparam logic [3:0] CMD_IDLE      = 4'd0;
    localparam logic [3:0] CMD_LOAD      = 4'd1;  // latch price, pick sides
    localparam logic [3:0] CMD_RD_TOP    = 4'd2;  // read opposite heap root
    localparam logic [3:0] CMD_DECIDE    = 4'd3;  // match, rest or drop
    localparam logic [3:0] CMD_UP_RD     = 4'd4;  // read parent during push
    localparam logic [3:0] CMD_UP_STEP   = 4'd5;  // compare and move parent down
    localparam logic [3:0] CMD_DN_RDLAST = 4'd6;  // read last entry for pop
    localparam logic [3:0] CMD_DN_VAL    = 4'd7;  // hold last entry as sifted value
    localparam logic [3:0] CMD_DN_RDL    = 4'd8;  // read left child
    localparam logic [3:0] CMD_DN_RDR    = 4'd9;  // hold left child, read right child
    localparam logic [3:0] CMD_DN_STEP   = 4'd10; // compare and move child up
    localparam logic [3:0] CMD_FINISH    = 4'd11; // write held value

    typedef struct packed {
        logic [3:0] cmd;
    } lomh_ctrl_t;

    typedef struct packed {
        logic is_zero;
        logic do_match;
        logic do_rest;
        logic pos_zero;
        logic up_done;
        logic n_zero;
        logic kid_out;
        logic dn_done;
    } lomh_stat_t;

endpackage

### rtl/lomh_datapath.sv
// Datapath of the order matcher: both heap memories, counts and sift registers.
module lomh_datapath #(
    parameter int BOOK_DEPTH  = lomh_pkg::BOOK_DEPTH_DEF,
    parameter int PRICE_WIDTH = lomh_pkg::PRICE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lomh_pkg::lomh_ctrl_t          ctrl,
    output lomh_pkg::lomh_stat_t          stat,
    input  logic signed [PRICE_WIDTH-1:0] price,
    output logic signed [PRICE_WIDTH-1:0] res_match,
    output logic                          res_rested,
    output logic                          res_full
);
    localparam int AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int KW = AW + 2;

    logic signed [PRICE_WIDTH-1:0] buy_mem  [BOOK_DEPTH];
    logic signed [PRICE_WIDTH-1:0] sell_mem [BOOK_DEPTH];

    logic [CW-1:0] buy_cnt_reg,  buy_cnt_next;
    logic [CW-1:0] sell_cnt_reg, sell_cnt_next;

    logic signed [PRICE_WIDTH-1:0] price_reg;
    logic                          buy_side_reg;   // order is a buy
    logic                          heap_sel_reg;   // 1 works on buy heap
    logic signed [PRICE_WIDTH-1:0] val_reg;        // value being sifted
    logic signed [PRICE_WIDTH-1:0] lkid_reg;
    logic [AW-1:0]                 pos_reg;
    logic [CW-1:0]                 n_reg;          // heap size for pop
    logic signed [PRICE_WIDTH-1:0] rd_data_reg;
    logic                          match_reg, rest_reg, full_reg;
    logic signed [PRICE_WIDTH-1:0] mout_reg;

    // Memory port signals.
    logic                          we, rd_en;
    logic [AW-1:0]                 waddr, raddr;
    logic signed [PRICE_WIDTH-1:0] wdata;

    logic [AW-1:0]                 parent_pos;
    logic [KW-1:0]                 lkid_pos, rkid_pos, big_pos;
    logic [CW-1:0]                 opp_cnt, own_cnt;
    logic                          sum_pos, opp_hit, has_right, right_wins;
    logic signed [PRICE_WIDTH:0]   sum;
    logic signed [PRICE_WIDTH-1:0] big_val;
    logic                          is_zero, do_match, do_rest, up_done, dn_done, kid_out;

    assign parent_pos = (pos_reg - AW'(1)) >> 1;
    assign lkid_pos   = {1'b0, pos_reg, 1'b1};
    assign rkid_pos   = lkid_pos + KW'(1);
    assign has_right  = (rkid_pos < KW'(n_reg));

    // During a step the right child sits in the read register and the left one in lkid_reg.
    assign right_wins = has_right && (rd_data_reg > lkid_reg);
    assign big_val    = right_wins ? rd_data_reg : lkid_reg;
    assign big_pos    = right_wins ? rkid_pos : lkid_pos;

    assign opp_cnt = buy_side_reg ? sell_cnt_reg : buy_cnt_reg;
    assign own_cnt = buy_side_reg ? buy_cnt_reg  : sell_cnt_reg;
    assign sum     = {price_reg[PRICE_WIDTH-1], price_reg} +
                     {rd_data_reg[PRICE_WIDTH-1], rd_data_reg};
    assign sum_pos = !sum[PRICE_WIDTH] && (sum != '0);
    assign opp_hit = (opp_cnt != '0) && sum_pos;

    assign is_zero  = (price_reg == '0);
    assign do_match = !is_zero && opp_hit;
    assign do_rest  = !is_zero && !opp_hit && (own_cnt != CW'(BOOK_DEPTH));
    assign up_done  = (rd_data_reg >= val_reg);
    assign dn_done  = (big_val <= val_reg);
    assign kid_out  = (lkid_pos >= KW'(n_reg));

    always_comb
    begin
        stat.is_zero  = is_zero;
        stat.do_match = do_match;
        stat.do_rest  = do_rest;
        stat.pos_zero = (pos_reg == '0);
        stat.up_done  = up_done;
        stat.n_zero   = (n_reg == '0);
        stat.kid_out  = kid_out;
        stat.dn_done  = dn_done;
    end

    // Read address per command.
    always_comb
    begin
        rd_en = 1'b0;
        raddr = '0;
        unique case (ctrl.cmd)
            lomh_pkg::CMD_RD_TOP:
                rd_en = 1'b1;
            lomh_pkg::CMD_UP_RD:
            begin
                rd_en = 1'b1;
                raddr = parent_pos;
            end
            lomh_pkg::CMD_DN_RDLAST:
            begin
                rd_en = 1'b1;
                raddr = AW'(n_reg);
            end
            lomh_pkg::CMD_DN_RDL:
            begin
                rd_en = 1'b1;
                raddr = AW'(lkid_pos);
            end
            lomh_pkg::CMD_DN_RDR:
            begin
                rd_en = has_right;
                raddr = AW'(rkid_pos);
            end
            default: rd_en = 1'b0;
        endcase
    end

    // Write port per command.
    always_comb
    begin
        we    = 1'b0;
        waddr = pos_reg;
        wdata = val_reg;
        unique case (ctrl.cmd)
            lomh_pkg::CMD_UP_STEP:
            begin
                if (!up_done)
                begin
                    we    = 1'b1;
                    wdata = rd_data_reg;
                end
            end
            lomh_pkg::CMD_DN_STEP:
            begin
                if (!dn_done)
                begin
                    we    = 1'b1;
                    wdata = big_val;
                end
            end
            lomh_pkg::CMD_FINISH:
                we = rest_reg || (match_reg && n_reg != '0);
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we && heap_sel_reg)
            buy_mem[waddr] <= wdata;
        if (we && !heap_sel_reg)
            sell_mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= heap_sel_reg ? buy_mem[raddr] : sell_mem[raddr];
    end

    always_comb
    begin
        buy_cnt_next  = buy_cnt_reg;
        sell_cnt_next = sell_cnt_reg;
        if (ctrl.cmd == lomh_pkg::CMD_DECIDE)
        begin
            if (do_match)
            begin
                if (buy_side_reg) sell_cnt_next = sell_cnt_reg - CW'(1);
                else              buy_cnt_next  = buy_cnt_reg - CW'(1);
            end
            else if (do_rest)
            begin
                if (buy_side_reg) buy_cnt_next  = buy_cnt_reg + CW'(1);
                else              sell_cnt_next = sell_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buy_cnt_reg  <= '0;
            sell_cnt_reg <= '0;
        end
        else
        begin
            buy_cnt_reg  <= buy_cnt_next;
            sell_cnt_reg <= sell_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.cmd)
            lomh_pkg::CMD_LOAD:
            begin
                price_reg    <= price;
                buy_side_reg <= !price[PRICE_WIDTH-1];
                heap_sel_reg <= price[PRICE_WIDTH-1]; // opposite heap first
                match_reg    <= 1'b0;
                rest_reg     <= 1'b0;
                full_reg     <= 1'b0;
                mout_reg     <= '0;
            end
            lomh_pkg::CMD_DECIDE:
            begin
                if (do_match)
                begin
                    match_reg <= 1'b1;
                    mout_reg  <= rd_data_reg;
                    n_reg     <= opp_cnt - CW'(1);
                    pos_reg   <= '0;
                end
                else if (do_rest)
                begin
                    rest_reg     <= 1'b1;
                    heap_sel_reg <= buy_side_reg;
                    val_reg      <= price_reg;
                    pos_reg      <= AW'(own_cnt);
                end
                else if (!is_zero)
                    full_reg <= 1'b1;
            end
            lomh_pkg::CMD_UP_STEP:
                if (!up_done)
                    pos_reg <= parent_pos;
            lomh_pkg::CMD_DN_VAL:
                val_reg <= rd_data_reg;
            lomh_pkg::CMD_DN_RDR:
                lkid_reg <= rd_data_reg;
            lomh_pkg::CMD_DN_STEP:
                if (!dn_done)
                    pos_reg <= AW'(big_pos);
            default: ;
        endcase
    end

    assign res_match  = mout_reg;
    assign res_rested = rest_reg;
    assign res_full   = full_reg;
endmodule

### rtl/lomh_ctrl.sv
// Controller of the order matcher: sequences reads, compares and writes.
module lomh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lomh_pkg::lomh_ctrl_t ctrl,
    input  lomh_pkg::lomh_stat_t stat
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TOP    = 4'd1;
    localparam logic [3:0] S_DEC    = 4'd2;
    localparam logic [3:0] S_URD    = 4'd3;
    localparam logic [3:0] S_USTEP  = 4'd4;
    localparam logic [3:0] S_DLAST  = 4'd5;
    localparam logic [3:0] S_DVAL   = 4'd6;
    localparam logic [3:0] S_DL     = 4'd7;
    localparam logic [3:0] S_DR     = 4'd8;
    localparam logic [3:0] S_DSTEP  = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0] state_reg, state_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        ctrl.cmd   = lomh_pkg::CMD_IDLE;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    ctrl.cmd   = lomh_pkg::CMD_LOAD;
                    state_next = S_TOP;
                end
            S_TOP:
            begin
                ctrl.cmd   = lomh_pkg::CMD_RD_TOP;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                ctrl.cmd = lomh_pkg::CMD_DECIDE;
                if (stat.do_match)     state_next = S_DLAST;
                else if (stat.do_rest) state_next = S_URD;
                else                   state_next = S_OUT;
            end
            S_URD:
            begin
                if (stat.pos_zero)
                    state_next = S_FIN;
                else
                begin
                    ctrl.cmd   = lomh_pkg::CMD_UP_RD;
                    state_next = S_USTEP;
                end
            end
            S_USTEP:
            begin
                ctrl.cmd   = lomh_pkg::CMD_UP_STEP;
                state_next = stat.up_done ? S_FIN : S_URD;
            end
            S_DLAST:
            begin
                // Popping the only entry leaves nothing to move.
                if (stat.n_zero)
                    state_next = S_FIN;
                else
                begin
                    ctrl.cmd   = lomh_pkg::CMD_DN_RDLAST;
                    state_next = S_DVAL;
                end
            end
            S_DVAL:
            begin
                ctrl.cmd   = lomh_pkg::CMD_DN_VAL;
                state_next = S_DL;
            end
            S_DL:
            begin
                if (stat.kid_out)
                    state_next = S_FIN;
                else
                begin
                    ctrl.cmd   = lomh_pkg::CMD_DN_RDL;
                    state_next = S_DR;
                end
            end
            S_DR:
            begin
                ctrl.cmd   = lomh_pkg::CMD_DN_RDR;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                ctrl.cmd   = lomh_pkg::CMD_DN_STEP;
                state_next = stat.dn_done ? S_FIN : S_DL;
            end
            S_FIN:
            begin
                ctrl.cmd   = lomh_pkg::CMD_FINISH;
                state_next = S_OUT;
            end
            S_OUT:
                if (!out_stall)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

### rtl/limit_order_matcher_heap.sv
// Top level of the heap-based limit order matcher.
// One order is taken at a time: the input is stalled from the transfer of an
// order until its result has been transferred. A zero price or a dropped order
// goes from the read of the opposite root straight to its result. A resting
// order climbs its heap, reading the parent and comparing at each level. A
// match that empties the heap moves nothing; otherwise the last entry is read,
// held as the new root and sunk, reading the left child, then the right child,
// then comparing at each level. Each heap is one memory read and written at
// one entry per cycle.
module limit_order_matcher_heap #(
    parameter int BOOK_DEPTH  = lomh_pkg::BOOK_DEPTH_DEF,
    parameter int PRICE_WIDTH = lomh_pkg::PRICE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [PRICE_WIDTH-1:0] price,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [PRICE_WIDTH-1:0] match_price,
    output logic                          rested,
    output logic                          book_full
);
    lomh_pkg::lomh_ctrl_t ctrl;
    lomh_pkg::lomh_stat_t stat;

    lomh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    lomh_datapath #(
        .BOOK_DEPTH  (BOOK_DEPTH),
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .price      (price),
        .res_match  (match_price),
        .res_rested (rested),
        .res_full   (book_full)
    );
endmodule

### verif/tb_limit_order_matcher_heap.sv
// Self-checking testbench for the heap-based limit order matcher.
`timescale 1ns / 1ps

module tb_limit_order_matcher_heap;

    localparam int DEPTH      = lomh_pkg::BOOK_DEPTH_DEF;
    localparam int PW         = lomh_pkg::PRICE_WIDTH_DEF;
    localparam int NUM_ORDERS = 1350;
    localparam int FILL_AT    = 300;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 200;

    typedef enum int {BUY_SIDE = 0, SELL_SIDE = 1} book_side_e;

    typedef struct packed {
        logic signed [PW-1:0] match_price;
        logic                 rested;
        logic                 book_full;
    } fill_report_t;

    typedef struct {
        logic signed [PW-1:0] price;
        bit                   known;
        fill_report_t         report;
    } order_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [PW-1:0] price;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [PW-1:0] match_price;
    logic                 rested;
    logic                 book_full;

    // Shadow order book: max-heaps of buy prices and of negated sell prices.
    longint       resting[2][DEPTH];
    int           rest_cnt[2];
    fill_report_t pending_reports[$];
    int           mismatches;
    int           idle_cycles;
    int           stall_left;
    bit           calm;
    order_row_t   opening[21];

    limit_order_matcher_heap i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .price       (price),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .match_price (match_price),
        .rested      (rested),
        .book_full   (book_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void heap_insert(int s, longint v);
        int pos;
        int up;
        pos = rest_cnt[s];
        while (pos > 0)
        begin
            up = (pos - 1) / 2;
            if (resting[s][up] >= v)
                break;
            resting[s][pos] = resting[s][up];
            pos = up;
        end
        resting[s][pos] = v;
        rest_cnt[s]++;
    endfunction

    function automatic void heap_take_top(int s);
        int     n;
        int     pos;
        int     kid;
        longint v;
        n = rest_cnt[s] - 1;
        v = resting[s][n];
        pos = 0;
        rest_cnt[s] = n;
        while (1)
        begin
            kid = 2 * pos + 1;
            if (kid >= n)
                break;
            if (kid + 1 < n && resting[s][kid + 1] > resting[s][kid])
                kid = kid + 1;
            if (resting[s][kid] <= v)
                break;
            resting[s][pos] = resting[s][kid];
            pos = kid;
        end
        if (n > 0)
            resting[s][pos] = v;
    endfunction

    function automatic fill_report_t match_order(logic signed [PW-1:0] p);
        fill_report_t r;
        longint       v;
        int           own;
        int           opp;
        r = '0;
        v = p;
        if (v == 0)
            return r;
        own = (v > 0) ? BUY_SIDE : SELL_SIDE;
        opp = (v > 0) ? SELL_SIDE : BUY_SIDE;
        if (rest_cnt[opp] > 0 && v + resting[opp][0] > 0)
        begin
            r.match_price = resting[opp][0][PW-1:0];
            heap_take_top(opp);
            return r;
        end
        if (rest_cnt[own] >= DEPTH)
        begin
            r.book_full = 1'b1;
            return r;
        end
        heap_insert(own, v);
        r.rested = 1'b1;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [PW-1:0] random_price();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000001;
                    2: return 32'sh80000000;
                    3: return 32'sd1;
                    default: return -32'sd1;
                endcase
            end
            // A narrow band makes equal-sum ties and near misses common.
            2, 3, 4: return $signed($urandom_range(0, 40)) - 32'sd20;
            default: return $urandom();
        endcase
    endfunction

    // Holds the transfer until accepted; the expectation is queued at acceptance.
    task automatic send_order(logic signed [PW-1:0] p, bit known, fill_report_t known_rep);
        int           gap;
        fill_report_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        price    <= p;
        do
            @(posedge clk);
        while (in_stall);
        predicted = match_order(p);
        pending_reports.push_back(known ? known_rep : predicted);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: match_price=%0d rested=%0b full=%0b",
                             match_price, rested, book_full);
            end
            else
            begin
                fill_report_t want;
                want = pending_reports.pop_front();
                if (match_price !== want.match_price || rested !== want.rested ||
                    book_full !== want.book_full)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d %0b %0b, got %0d %0b %0b",
                                 want.match_price, want.rested, want.book_full,
                                 match_price, rested, book_full);
                end
            end
        end
    end

    // Result-side back-pressure: mostly free, short stalls, occasional long ones.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (calm || $urandom_range(0, 99) < 70)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= 1'b1;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(0, 2);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int extra;
        in_valid    = 1'b0;
        price       = '0;
        out_stall   = 1'b0;
        rst_n       = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        calm        = 1'b0;
        rest_cnt[BUY_SIDE]  = 0;
        rest_cnt[SELL_SIDE] = 0;

        opening = '{
            '{32'sd0,           1'b1, '{32'sd0, 1'b0, 1'b0}},
            '{32'sd1,           1'b1, '{32'sd0, 1'b1, 1'b0}},
            '{-32'sd1,          1'b1, '{32'sd0, 1'b1, 1'b0}},  // sum is zero: rests
            '{32'sd2,           1'b1, '{-32'sd1, 1'b0, 1'b0}},
            '{32'sh7fffffff,    1'b1, '{32'sd0, 1'b1, 1'b0}},
            '{32'sh80000000,    1'b1, '{32'sd0, 1'b1, 1'b0}},  // most negative pattern
            '{-32'sd1,          1'b1, '{32'sh7fffffff, 1'b0, 1'b0}},
            '{32'sh80000001,    1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{32'sh7fffffff,    1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{32'sd5,           1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{-32'sd3,          1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{-32'sd4,          1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{32'sd3,           1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{32'sd4,           1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{32'sd0,           1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{-32'sd100,        1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{32'sd100,         1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{32'sd50,          1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{-32'sd50,         1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{32'sd1,           1'b0, '{32'sd0, 1'b0, 1'b0}},
            '{-32'sd2,          1'b0, '{32'sd0, 1'b0, 1'b0}}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_order(opening[i].price, opening[i].known, opening[i].report);

        n = 0;
        while (n < NUM_ORDERS)
        begin
            if (n == FILL_AT)
            begin
                // Build the buy side up to its depth, then push past it.
                calm = 1'b1;
                while (rest_cnt[BUY_SIDE] < DEPTH)
                begin
                    if (rest_cnt[BUY_SIDE] == DEPTH / 2)
                        calm = 1'b0;
                    send_order($urandom_range(1, 1000), 1'b0, '0);
                    n++;
                end
                for (extra = 0; extra < 6; extra++)
                begin
                    send_order($urandom_range(1, 1000), 1'b0, '0);
                    n++;
                end
            end
            send_order(random_price(), 1'b0, '0);
            n++;
        end
        @(posedge clk);
        in_valid <= 1'b0;

        while (pending_reports.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
